### rtl/core/wstq_pkg.sv
// Shared types and codes of the work-stealing task queues.
`default_nettype none

package wstq_pkg;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_GIVEN  = 3'd2,
    ST_NONE   = 3'd3,
    ST_BADW   = 3'd4
  } status_e;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam int unsigned TagPortWidth   = 16;
  localparam int unsigned ActiveWidth    = 4;
  localparam logic [ActiveWidth-1:0] ActiveReset = 4'd8;

endpackage

`default_nettype wire

### rtl/core/wstq_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module wstq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/work_stealing_task_queues.sv
// The task memory read and the stage fill happen when an input word is accepted; the output
// register then loads the result word from the stage once the output is not stalled.
// The block takes no new input word until the single stage between the task memory read and
// the output register has passed the previous word on, and a stalled output keeps it in the stage.
// Reset clears all deque heads and fills, the pending count and the staging/output
// valid flags, and sets active_workers to 8; the task memory itself is not cleared.
`default_nettype none

module work_stealing_task_queues import wstq_pkg::*; #(
  parameter int unsigned MAX_WORKERS = 8,
  parameter int unsigned DEQUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [ActiveWidth-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   func_i,
  input  wire logic [2:0]             worker_index_i,
  input  wire logic [15:0]            task_tag_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [15:0]                 task_out_o,
  output logic [2:0]                  source_worker_o,
  output logic                        was_stolen_o,
  output logic [7:0]                  pending_out_o
);

  localparam int unsigned WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned HW = $clog2(DEQUE_DEPTH);
  localparam int unsigned FW = $clog2(DEQUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(MAX_WORKERS * DEQUE_DEPTH + 1);
  localparam int unsigned RD = MAX_WORKERS * DEQUE_DEPTH;
  localparam int unsigned AW = $clog2(RD);
  localparam int unsigned SW = (TAG_WIDTH < TagPortWidth) ? TAG_WIDTH : TagPortWidth;

  // deque pointers and counters
  logic [HW-1:0]          head_q [MAX_WORKERS];
  logic [HW-1:0]          head_d [MAX_WORKERS];
  logic [FW-1:0]          fill_q [MAX_WORKERS];
  logic [FW-1:0]          fill_d [MAX_WORKERS];
  logic [PW-1:0]          pending_q, pending_d;
  logic [ActiveWidth-1:0] active_q;

  // stage between memory read and output register
  logic                   stg_valid_q, stg_valid_d;
  status_e                stg_status_q, stg_status_d;
  logic [WW-1:0]          stg_src_q, stg_src_d;
  logic                   stg_stolen_q, stg_stolen_d;
  logic [PW-1:0]          stg_pending_q;
  logic                   stg_move;

  logic                   out_valid_q;
  logic [2:0]             out_status_q;
  logic [15:0]            out_task_q;
  logic [2:0]             out_src_q;
  logic                   out_stolen_q;
  logic [7:0]             out_pending_q;

  // decode
  logic                   accept;
  logic [NW-1:0]          n_eff;
  logic                   bad;
  logic [WW-1:0]          wi;
  logic                   own_empty, own_full;
  logic [WW:0]            cand;
  logic [WW-1:0]          victim;
  logic                   victim_found;
  logic [WW-1:0]          sel_w;
  logic [HW:0]            pos_raw;
  logic [HW:0]            pos_wrap;
  logic [HW-1:0]          slot_pos;
  logic [HW:0]            head_inc;

  logic                   ram_en, ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SW-1:0]          ram_rdata;

  assign accept     = in_valid_i & ~stg_valid_q;
  assign in_stall_o = stg_valid_q;

  always_comb begin
    if (active_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(active_q) > int'(MAX_WORKERS)) begin
      n_eff = NW'(MAX_WORKERS);
    end else begin
      n_eff = NW'(active_q);
    end
  end

  assign bad       = int'(worker_index_i) >= int'(n_eff);
  assign wi        = WW'(worker_index_i);
  assign own_empty = (fill_q[wi] == '0);
  assign own_full  = (int'(fill_q[wi]) >= int'(DEQUE_DEPTH));

  // round-robin priority scan for a victim, starting at self+1
  always_comb begin
    victim_found = 1'b0;
    victim       = '0;
    cand         = '0;
    for (int k = 1; k <= int'(MAX_WORKERS); k++) begin
      cand = (WW+1)'(wi) + (WW+1)'(k);
      if (cand >= (WW+1)'(n_eff)) begin
        cand = cand - (WW+1)'(n_eff);
      end
      if (k <= int'(n_eff) && !victim_found && fill_q[cand[WW-1:0]] != '0) begin
        victim_found = 1'b1;
        victim       = cand[WW-1:0];
      end
    end
  end

  assign sel_w = (func_i == FUNC_TAKE && own_empty) ? victim : wi;

  always_comb begin
    if (func_i == FUNC_PUSH) begin
      pos_raw = {1'b0, head_q[wi]} + (HW+1)'(fill_q[wi]);
    end else if (!own_empty) begin
      pos_raw = {1'b0, head_q[wi]} + (HW+1)'(fill_q[wi]) - (HW+1)'(1);
    end else begin
      pos_raw = {1'b0, head_q[victim]};
    end
    pos_wrap = (int'(pos_raw) >= int'(DEQUE_DEPTH)) ? pos_raw - (HW+1)'(DEQUE_DEPTH) : pos_raw;
    slot_pos = pos_wrap[HW-1:0];
    head_inc = {1'b0, head_q[victim]} + (HW+1)'(1);
    if (int'(head_inc) >= int'(DEQUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  assign ram_addr = AW'(int'(sel_w) * DEQUE_DEPTH + int'(slot_pos));

  always_comb begin
    head_d       = head_q;
    fill_d       = fill_q;
    pending_d    = pending_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    stg_status_d = ST_NONE;
    stg_src_d    = '0;
    stg_stolen_d = 1'b0;
    if (bad) begin
      stg_status_d = ST_BADW;
    end else if (func_i == FUNC_PUSH) begin
      if (own_full) begin
        stg_status_d = ST_FULL;
      end else begin
        stg_status_d = ST_PUSHED;
        ram_en       = accept;
        ram_we       = 1'b1;
        fill_d[wi]   = fill_q[wi] + FW'(1);
        pending_d    = pending_q + PW'(1);
      end
    end else if (!own_empty) begin
      stg_status_d = ST_GIVEN;
      stg_src_d    = wi;
      ram_en       = accept;
      fill_d[wi]   = fill_q[wi] - FW'(1);
      pending_d    = pending_q - PW'(1);
    end else if (victim_found) begin
      stg_status_d   = ST_GIVEN;
      stg_src_d      = victim;
      stg_stolen_d   = 1'b1;
      ram_en         = accept;
      fill_d[victim] = fill_q[victim] - FW'(1);
      head_d[victim] = head_inc[HW-1:0];
      pending_d      = pending_q - PW'(1);
    end
  end

  wstq_ram #(
    .WIDTH(SW),
    .DEPTH(RD)
  ) u_task_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(SW'(task_tag_i)),
    .rdata_o(ram_rdata)
  );

  assign stg_move    = stg_valid_q & (~out_valid_q | ~out_stall_i);
  assign stg_valid_d = accept | (stg_valid_q & ~stg_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_WORKERS); i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
      pending_q   <= '0;
      active_q    <= ActiveReset;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q    <= head_d;
        fill_q    <= fill_d;
        pending_q <= pending_d;
      end
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      stg_valid_q <= stg_valid_d;
      if (stg_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_status_q  <= stg_status_d;
      stg_src_q     <= stg_src_d;
      stg_stolen_q  <= stg_stolen_d;
      stg_pending_q <= pending_d;
    end
    if (stg_move) begin
      out_status_q  <= stg_status_q;
      out_task_q    <= (stg_status_q == ST_GIVEN) ? TagPortWidth'(ram_rdata) : '0;
      out_src_q     <= 3'(stg_src_q);
      out_stolen_q  <= stg_stolen_q;
      out_pending_q <= 8'(stg_pending_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign task_out_o      = out_task_q;
  assign source_worker_o = out_src_q;
  assign was_stolen_o    = out_stolen_q;
  assign pending_out_o   = out_pending_q;

endmodule

`default_nettype wire

### rtl/core/wstq_checker.sv
// Port-level assertions for the work-stealing task queues, bound to the top level.
`default_nettype none

module wstq_checker import wstq_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [2:0]             status_o,
  input wire logic [15:0]            task_out_o,
  input wire logic [2:0]             source_worker_o,
  input wire logic                   was_stolen_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(task_out_o) && $stable(status_o))
    else $error("stalled result word changed");

  // only a given task carries a tag, a source and a steal flag
  a_given_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_GIVEN |->
      task_out_o == '0 && source_worker_o == '0 && !was_stolen_o)
    else $error("non-given result carries task fields");

  // one word in flight: an accepted word blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // a fresh result follows an accepted word that has passed through the stage
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without accepted word");

endmodule

bind work_stealing_task_queues wstq_checker u_wstq_checker (.*);

`default_nettype wire
